### rtl/vag_pkg.sv
// Shared types, constants and helpers for the vector arrow glyph unit.
// Depends on nothing; every other file imports it or is independent of it.
package vag_pkg;

    localparam int CFG_W = 31;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [29:0] ROT_COS  = 30'd942297101;
    localparam logic [29:0] ROT_SIN  = 30'd514779252;
    localparam logic [31:0] RECIP5   = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        CFG_MAG_LOW,
        CFG_MAG_HIGH,
        CFG_EDGE_SHORT,
        CFG_EDGE_LONG
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               sx;
        logic               sy;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_sq_side;

    typedef struct packed {
        logic [7:0]         shade_idx;
        logic signed [31:0] tip_x;
        logic signed [31:0] tip_y;
        logic signed [31:0] barb_a_x;
        logic signed [31:0] barb_a_y;
        logic signed [31:0] barb_b_x;
        logic signed [31:0] barb_b_y;
    } t_glyph;

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/vag_in_if.sv
// Input channel of the vector arrow glyph unit: one vector and its base point.
// Standalone valid/ready interface with no dependencies.
interface vag_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;

    modport source (output valid, comp_x, comp_y, base_x, base_y, input ready);
    modport sink   (input valid, comp_x, comp_y, base_x, base_y, output ready);
endinterface

### rtl/vag_out_if.sv
// Output channel of the vector arrow glyph unit: color index and arrow points.
// Standalone valid/ready interface with no dependencies.
interface vag_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         shade_idx;
    logic signed [31:0] tip_x;
    logic signed [31:0] tip_y;
    logic signed [31:0] barb_a_x;
    logic signed [31:0] barb_a_y;
    logic signed [31:0] barb_b_x;
    logic signed [31:0] barb_b_y;

    modport source (output valid, shade_idx, tip_x, tip_y, barb_a_x, barb_a_y,
                    barb_b_x, barb_b_y, input ready);
    modport sink   (input valid, shade_idx, tip_x, tip_y, barb_a_x, barb_a_y,
                    barb_b_x, barb_b_y, output ready);
endinterface

### rtl/vag_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with a sideband.
// Self-contained; used by vector_arrow_glyph_unit.
module vag_sqrt_pipe #(
    parameter int NW = 32,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*NW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [NW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    logic [NW+1:0]   r_rem  [NW];
    logic [NW-1:0]   r_root [NW];
    logic [2*NW-1:0] r_rad  [NW];
    logic [SW-1:0]   r_side [NW];
    logic [NW-1:0]   r_v;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW+1:0]   p_rem;
        logic [NW-1:0]   p_root;
        logic [2*NW-1:0] p_rad;
        logic [SW-1:0]   p_side;
        logic [NW+3:0]   t;
        logic [NW+3:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
        end

        assign t     = {p_rem, p_rad[2*NW-1 -: 2]};
        assign trial = {2'b00, p_root, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (NW+2)'(t - trial) : t[NW+1:0];
                r_root[k] <= {p_root[NW-2:0], ge};
                r_rad[k]  <= p_rad << 2;
                r_side[k] <= p_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NW-2:0], i_valid};
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_root  = r_root[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

### rtl/vag_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Self-contained; used by vector_arrow_glyph_unit.
module vag_div_pipe #(
    parameter int QW = 31,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_div,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_div  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_v;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_div;
        logic [QW-1:0] p_low;
        logic [QW-1:0] p_quo;
        logic [SW-1:0] p_side;
        logic [DW:0]   t;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_rem  = i_rem;
            assign p_div  = i_div;
            assign p_low  = i_low;
            assign p_quo  = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_div  = r_div[k-1];
            assign p_low  = r_low[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_side = r_side[k-1];
        end

        assign t  = {p_rem, p_low[QW-1]};
        assign ge = (t >= {1'b0, p_div});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? DW'(t - {1'b0, p_div}) : t[DW-1:0];
                r_div[k]  <= p_div;
                r_low[k]  <= p_low << 1;
                r_quo[k]  <= {p_quo[QW-2:0], ge};
                r_side[k] <= p_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

### rtl/vector_arrow_glyph_unit.sv
// Vector arrow glyph unit: top level with config registers, pipeline and output skid.
// Depends on vag_pkg, vag_in_if, vag_out_if, vag_sqrt_pipe and vag_div_pipe.

// The unit takes one vector item per clock cycle while its output skid register is empty,
// and returns one glyph item for each. The pipeline depth is set by the square root, which
// resolves one root bit per stage over 32 stages, and the four dividers, which resolve one
// quotient bit per stage over 31 stages; around them are registered stages for the squares,
// the clamp, the rotation products and the final saturating adds. An output skid register
// holds a finished glyph while the output stalls, so a stalled output loses nothing; while
// it is full, the input and the pipeline stall. Configuration passes through registers first.
module vector_arrow_glyph_unit import vag_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    vag_in_if.sink           i_item,
    vag_out_if.source        o_glyph
);

    // Configuration and derived constants.
    logic [CFG_W-1:0] r_mag_low, r_mag_high, r_edge_short, r_edge_long;
    logic [63:0]      r_p5;
    logic [30:0]      r_lo, r_ad, r_rng, n_lo, n_ad;
    logic             r_neg, r_dg, n_neg;
    t_cfg_idx         cfg_sel;

    assign cfg_sel = t_cfg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_low    <= 31'd0;
            r_mag_high   <= 31'd65536;
            r_edge_short <= 31'd65536;
            r_edge_long  <= 31'd131072;
        end else if (i_cfg_we) begin
            unique case (cfg_sel)
                CFG_MAG_LOW:    r_mag_low    <= i_cfg_data;
                CFG_MAG_HIGH:   r_mag_high   <= i_cfg_data;
                CFG_EDGE_SHORT: r_edge_short <= i_cfg_data;
                CFG_EDGE_LONG:  r_edge_long  <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        logic [33:0] s5;
        logic [31:0] s2;
        s5 = {1'b0, r_edge_short, 2'b00} + 34'(r_edge_short);
        s2 = {r_edge_short, 1'b0};
        n_lo  = r_edge_short;
        n_ad  = r_edge_short;
        n_neg = 1'b0;
        if (32'(r_edge_long) > s2) begin
            if (34'(r_edge_long) > s5) begin
                n_lo = {1'b0, r_p5[63:34]};
            end
        end else if (r_edge_long < r_edge_short) begin
            n_neg = 1'b1;
            n_ad  = r_edge_short - r_edge_long;
        end else begin
            n_ad  = r_edge_long - r_edge_short;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p5  <= 64'(32'(r_edge_short) + 32'(r_edge_long)) * 64'(RECIP5);
        r_lo  <= n_lo;
        r_ad  <= n_ad;
        r_neg <= n_neg;
        r_rng <= r_mag_high - r_mag_low;
        r_dg  <= !(r_mag_high > r_mag_low);
    end

    // Pipeline control and output skid.
    logic   en;
    logic   r_sk_v;
    t_glyph r_sk, r10;
    logic   r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v;

    assign en           = !r_sk_v;
    assign i_item.ready = en;

    // Stage 1: absolute values.
    t_sq_side r1, r2, r3, sq_side, r4s, r5s;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1.sx <= i_item.comp_x[31];
            r1.sy <= i_item.comp_y[31];
            r1.ax <= i_item.comp_x[31] ? 32'(-i_item.comp_x) : i_item.comp_x;
            r1.ay <= i_item.comp_y[31] ? 32'(-i_item.comp_y) : i_item.comp_y;
            r1.bx <= i_item.base_x;
            r1.by <= i_item.base_y;
        end
    end

    // Stages 2 and 3: squares and their sum.
    logic [63:0] r2_sqx, r2_sqy, r3_rad;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2     <= r1;
            r2_sqx <= 64'(r1.ax) * 64'(r1.ax);
            r2_sqy <= 64'(r1.ay) * 64'(r1.ay);
            r3     <= r2;
            r3_rad <= r2_sqx + r2_sqy;
        end
    end

    logic        sq_v;
    logic [31:0] mag;

    vag_sqrt_pipe #(.NW(32), .SW($bits(t_sq_side))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_rad   (r3_rad),
        .i_side  (r3),
        .o_valid (sq_v),
        .o_root  (mag),
        .o_side  (sq_side)
    );

    // Stage 4: clamp magnitude into the range. Stage 5: dividend products.
    logic [31:0] dm, r4_mag, r5_mag;
    logic [30:0] d, r4_d;
    logic        r4_zero, r5_zero;
    logic [61:0] r5_p;
    logic [38:0] r5_dd;

    always_comb begin
        dm = (mag > {1'b0, r_mag_low}) ? mag - {1'b0, r_mag_low} : 32'd0;
        d  = (dm > {1'b0, r_rng}) ? r_rng : dm[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4s     <= sq_side;
            r4_mag  <= mag;
            r4_zero <= (mag == 32'd0);
            r4_d    <= d;
            r5s     <= r4s;
            r5_mag  <= r4_mag;
            r5_zero <= r4_zero;
            r5_p    <= 62'(r4_d) * 62'(r_ad);
            r5_dd   <= {r4_d, 8'd0} - 39'(r4_d);
        end
    end

    // Four parallel dividers: direction cosine and sine, length step and color index.
    logic        c_v, s_v, q_v, i_v;
    logic [30:0] c_quo, s_quo, q_quo, i_quo;
    logic        c_zero;
    logic [1:0]  s_sgn;
    logic [31:0] q_bx, i_by;

    vag_div_pipe #(.QW(31), .DW(32), .SW(1)) u_div_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r5_v),
        .i_div (r5_mag), .i_rem ({1'b0, r5s.ax[31:1]}), .i_low ({r5s.ax[0], 30'd0}),
        .i_side (r5_zero), .o_valid (c_v), .o_quo (c_quo), .o_side (c_zero)
    );

    vag_div_pipe #(.QW(31), .DW(32), .SW(2)) u_div_s (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r5_v),
        .i_div (r5_mag), .i_rem ({1'b0, r5s.ay[31:1]}), .i_low ({r5s.ay[0], 30'd0}),
        .i_side ({r5s.sx, r5s.sy}), .o_valid (s_v), .o_quo (s_quo), .o_side (s_sgn)
    );

    vag_div_pipe #(.QW(31), .DW(32), .SW(32)) u_div_q (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r5_v),
        .i_div ({1'b0, r_rng}), .i_rem ({1'b0, r5_p[61:31]}), .i_low (r5_p[30:0]),
        .i_side (r5s.bx), .o_valid (q_v), .o_quo (q_quo), .o_side (q_bx)
    );

    vag_div_pipe #(.QW(31), .DW(32), .SW(32)) u_div_i (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r5_v),
        .i_div ({1'b0, r_rng}), .i_rem ({24'd0, r5_dd[38:31]}), .i_low (r5_dd[30:0]),
        .i_side (r5s.by), .o_valid (i_v), .o_quo (i_quo), .o_side (i_by)
    );

    // Stage 6: direction, length and index.
    logic [30:0]        r6_c, r6_s;
    logic [31:0]        r6_len;
    logic [7:0]         r6_idx, r7_idx, r8_idx, r9_idx;
    logic               r6_sx, r6_sy, r7_sx, r7_sy, r8_sx, r8_sy, r9_sx, r9_sy;
    logic signed [31:0] r6_bx, r6_by, r7_bx, r7_by, r8_bx, r8_by;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_c   <= c_zero ? Q30_ONE : c_quo;
            r6_s   <= c_zero ? 31'd0 : s_quo;
            r6_len <= r_dg ? {1'b0, r_lo} :
                      (r_neg ? 32'(r_lo) - 32'(q_quo) : 32'(r_lo) + 32'(q_quo));
            r6_idx <= r_dg ? 8'd0 : i_quo[7:0];
            r6_sx  <= s_sgn[1];
            r6_sy  <= s_sgn[0];
            r6_bx  <= q_bx;
            r6_by  <= i_by;
        end
    end

    // Stage 7: rotation and head products.
    logic [60:0] r7_ck, r7_sj, r7_sk, r7_cj;
    logic [61:0] r7_lc, r7_ls;
    logic [63:0] r7_bp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ck  <= 61'(r6_c) * 61'(ROT_COS);
            r7_sj  <= 61'(r6_s) * 61'(ROT_SIN);
            r7_sk  <= 61'(r6_s) * 61'(ROT_COS);
            r7_cj  <= 61'(r6_c) * 61'(ROT_SIN);
            r7_lc  <= 62'(r6_len) * 62'(r6_c);
            r7_ls  <= 62'(r6_len) * 62'(r6_s);
            r7_bp  <= 64'(r6_len) * 64'(RECIP5);
            r7_idx <= r6_idx;
            r7_sx  <= r6_sx;
            r7_sy  <= r6_sy;
            r7_bx  <= r6_bx;
            r7_by  <= r6_by;
        end
    end

    // Stage 8: rotated direction magnitudes and signs, head offsets, barb length.
    logic [61:0] rax, ray, rbx, rby;
    logic [31:0] r8_rax, r8_ray, r8_rbx, r8_rby, r8_hx, r8_hy;
    logic        r8_nay, r8_nbx;
    logic [29:0] r8_bl;

    always_comb begin
        rax = 62'(r7_ck) + 62'(r7_sj);
        rby = 62'(r7_sk) + 62'(r7_cj);
        ray = (r7_sk >= r7_cj) ? 62'(r7_sk - r7_cj) : 62'(r7_cj - r7_sk);
        rbx = (r7_ck >= r7_sj) ? 62'(r7_ck - r7_sj) : 62'(r7_sj - r7_ck);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_rax <= rax[61:30];
            r8_ray <= ray[61:30];
            r8_rbx <= rbx[61:30];
            r8_rby <= rby[61:30];
            r8_nay <= (r7_sk < r7_cj) ^ r7_sy;
            r8_nbx <= (r7_ck < r7_sj) ^ r7_sx;
            r8_hx  <= r7_lc[61:30];
            r8_hy  <= r7_ls[61:30];
            r8_bl  <= r7_bp[63:34];
            r8_idx <= r7_idx;
            r8_sx  <= r7_sx;
            r8_sy  <= r7_sy;
            r8_bx  <= r7_bx;
            r8_by  <= r7_by;
        end
    end

    // Stage 9: barb offsets and head positions.
    logic [61:0]        pax, pay, pbx, pby;
    logic [31:0]        r9_dax, r9_day, r9_dbx, r9_dby;
    logic               r9_nay, r9_nbx;
    logic signed [33:0] r9_tx, r9_ty;

    always_comb begin
        pax = 62'(r8_bl) * 62'(r8_rax);
        pay = 62'(r8_bl) * 62'(r8_ray);
        pbx = 62'(r8_bl) * 62'(r8_rbx);
        pby = 62'(r8_bl) * 62'(r8_rby);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_dax <= pax[61:30];
            r9_day <= pay[61:30];
            r9_dbx <= pbx[61:30];
            r9_dby <= pby[61:30];
            r9_nay <= r8_nay;
            r9_nbx <= r8_nbx;
            r9_sx  <= r8_sx;
            r9_sy  <= r8_sy;
            r9_idx <= r8_idx;
            r9_tx  <= r8_sx ? 34'(r8_bx) - $signed({2'b00, r8_hx})
                            : 34'(r8_bx) + $signed({2'b00, r8_hx});
            r9_ty  <= r8_sy ? 34'(r8_by) - $signed({2'b00, r8_hy})
                            : 34'(r8_by) + $signed({2'b00, r8_hy});
        end
    end

    // Stage 10: barb ends and saturation.
    logic signed [34:0] tx35, ty35, bax, bay, bbx, bby;

    always_comb begin
        tx35 = 35'(r9_tx);
        ty35 = 35'(r9_ty);
        bax  = r9_sx  ? tx35 + $signed({3'b000, r9_dax}) : tx35 - $signed({3'b000, r9_dax});
        bay  = r9_nay ? ty35 + $signed({3'b000, r9_day}) : ty35 - $signed({3'b000, r9_day});
        bbx  = r9_nbx ? tx35 + $signed({3'b000, r9_dbx}) : tx35 - $signed({3'b000, r9_dbx});
        bby  = r9_sy  ? ty35 + $signed({3'b000, r9_dby}) : ty35 - $signed({3'b000, r9_dby});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10.shade_idx <= r9_idx;
            r10.tip_x     <= sat35(tx35);
            r10.tip_y     <= sat35(ty35);
            r10.barb_a_x  <= sat35(bax);
            r10.barb_a_y  <= sat35(bay);
            r10.barb_b_x  <= sat35(bbx);
            r10.barb_b_y  <= sat35(bby);
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
        end else if (en) begin
            r1_v  <= i_item.valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= sq_v;
            r5_v  <= r4_v;
            r6_v  <= c_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
        end
    end

    // Output skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (o_glyph.ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (r10_v && !o_glyph.ready) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) begin
            r_sk <= r10;
        end
    end

    t_glyph out_g;
    assign out_g                = r_sk_v ? r_sk : r10;
    assign o_glyph.valid        = r_sk_v || r10_v;
    assign o_glyph.shade_idx    = out_g.shade_idx;
    assign o_glyph.tip_x        = out_g.tip_x;
    assign o_glyph.tip_y        = out_g.tip_y;
    assign o_glyph.barb_a_x     = out_g.barb_a_x;
    assign o_glyph.barb_a_y     = out_g.barb_a_y;
    assign o_glyph.barb_b_x     = out_g.barb_b_x;
    assign o_glyph.barb_b_y     = out_g.barb_b_y;

    a_div_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_v == s_v) && (c_v == q_v) && (c_v == i_v))
        else $error("divider valid bits out of step");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_sk_v && r10_v && !o_glyph.ready) |=> (r_sk_v && !i_item.ready))
        else $error("stalled glyph not held in skid register");

    a_len_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_v && !r_neg) |-> (r6_len >= {1'b0, r_lo}))
        else $error("arrow length below lower edge bound");

endmodule
